// ----- hw/rtl/msf1_pkg.sv -----
// ----------------------------------------------------------------------------
// msf1_pkg
// Shared constants and item types for the masked span fill unit.
// ----------------------------------------------------------------------------
package msf1_pkg;

  localparam int ROW_PIXELS = 400;
  localparam int ROW_WORDS  = 13;
  localparam int ROW_COUNT  = 240;

  localparam int WORD_PIXELS = 32;
  localparam int ROW_W       = 8;
  localparam int COL_W       = 12;
  localparam int ADDR_W      = 12;
  localparam int DATA_W      = 32;

  // clipped column 0..ROW_PIXELS and word column 0..ROW_PIXELS/32
  localparam int PIX_W     = $clog2(ROW_PIXELS + 1);
  localparam int WORDS_MAX = (ROW_PIXELS - 1) / WORD_PIXELS + 1;
  localparam int WORD_W    = $clog2(WORDS_MAX + 1);
  localparam int BIT_W     = $clog2(WORD_PIXELS);

  localparam int CMD_DEPTH = 2;
  localparam int PTR_W     = $clog2(CMD_DEPTH);
  localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [COL_W-1:0] span_start;
    logic signed [COL_W-1:0] span_end;
    logic [DATA_W-1:0]       fill_pattern;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [DATA_W-1:0] write_mask;
    logic [DATA_W-1:0] write_data;
    logic              last_write;
  } result_t;

  // one classified span, ready for the write sequencer
  typedef struct packed {
    logic [ADDR_W-1:0] row_base;
    logic [WORD_W-1:0] word_first;
    logic [WORD_W-1:0] word_last;
    logic [BIT_W-1:0]  lo_first;   // first pixel inside the first word
    logic [BIT_W:0]    hi_last;    // end pixel inside the last word, 1..32
    logic              zero_len;   // empty span: single write with zero mask
    logic [DATA_W-1:0] data;
  } span_cmd_t;

endpackage

// ----- hw/rtl/msf1_front.sv -----
// ----------------------------------------------------------------------------
// msf1_front
// Clips a span request to the row and turns it into a word-range command.
// ----------------------------------------------------------------------------
module msf1_front
  import msf1_pkg::*;
(
  input  request_t  request,
  output logic      has_writes,
  output span_cmd_t cmd
);

  logic signed [COL_W:0] x1_ext;
  logic signed [COL_W:0] x2_ext;
  logic [PIX_W-1:0]      x1_clip;
  logic [PIX_W-1:0]      x2_clip;
  logic [PIX_W-1:0]      x2_dec;
  logic                  outside;

  always_comb begin
    x1_ext  = (COL_W + 1)'(request.span_start);
    x2_ext  = (COL_W + 1)'(request.span_end);
    outside = (x2_ext < 0) || (x1_ext >= (COL_W + 1)'(ROW_PIXELS));

    x1_clip = (x1_ext < 0) ? '0 : PIX_W'(x1_ext);
    x2_clip = (x2_ext > (COL_W + 1)'(ROW_PIXELS)) ? PIX_W'(ROW_PIXELS) : PIX_W'(x2_ext);
    x2_dec  = x2_clip - PIX_W'(1);

    has_writes = !outside && (x1_clip <= x2_clip);

    cmd.row_base   = ADDR_W'(request.row_index * ROW_WORDS);
    cmd.zero_len   = (x1_clip == x2_clip);
    cmd.word_first = WORD_W'(x1_clip >> BIT_W);
    cmd.word_last  = cmd.zero_len ? cmd.word_first : WORD_W'(x2_dec >> BIT_W);
    cmd.lo_first   = x1_clip[BIT_W-1:0];
    cmd.hi_last    = (BIT_W + 1)'(x2_dec[BIT_W-1:0]) + (BIT_W + 1)'(1);
    cmd.data       = request.fill_pattern;
  end

endmodule

// ----- hw/rtl/msf1_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// msf1_cmd_fifo
// Short command queue between span classification and the write sequencer.
// ----------------------------------------------------------------------------
module msf1_cmd_fifo
  import msf1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  span_cmd_t wr_cmd,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output span_cmd_t rd_cmd
);

  span_cmd_t        entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(CMD_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/msf1_back.sv -----
// ----------------------------------------------------------------------------
// msf1_back
// Write sequencer: steps through the words of a span into a single output
// register, one masked write a cycle while that register is free or popped.
// ----------------------------------------------------------------------------
module msf1_back
  import msf1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  span_cmd_t cmd_in,
  output logic      cmd_take,
  output logic      empty,
  input  logic      pop,
  output result_t   result
);

  span_cmd_t         cmd;
  logic              active;
  logic [WORD_W-1:0] word;
  logic              out_valid;
  result_t           out_reg;

  logic              issue;
  logic              at_first;
  logic              at_last;
  logic [BIT_W:0]    lo;
  logic [BIT_W:0]    hi;
  logic [BIT_W:0]    pix;
  result_t           word_res;

  assign issue    = active && (!out_valid || pop);
  assign at_first = (word == cmd.word_first);
  assign at_last  = (word == cmd.word_last);
  assign cmd_take = cmd_valid && (!active || (issue && at_last));

  always_comb begin
    lo = at_first ? (BIT_W + 1)'(cmd.lo_first) : '0;
    hi = at_last ? cmd.hi_last : (BIT_W + 1)'(WORD_PIXELS);
    word_res.word_address = cmd.row_base + ADDR_W'(word);
    word_res.write_data   = cmd.data;
    word_res.last_write   = at_last;
    word_res.write_mask   = '0;
    pix = '0;
    // bit j holds pixel j^7: MSB-first within each byte
    for (int j = 0; j < WORD_PIXELS; j++) begin
      pix = (BIT_W + 1)'(j ^ 7);
      word_res.write_mask[j] = !cmd.zero_len && (lo <= pix) && (pix < hi);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd <= cmd_in;
    end
    if (issue) begin
      out_reg <= word_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      word      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        active <= 1'b1;
        word   <= cmd_in.word_first;
      end else if (issue) begin
        if (at_last) begin
          active <= 1'b0;
        end else begin
          word <= word + WORD_W'(1);
        end
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

// ----- hw/rtl/masked_span_fill_1bpp_unit.sv -----
// ----------------------------------------------------------------------------
// masked_span_fill_1bpp_unit
// Splits a horizontal span of a 1-bit-per-pixel row into masked word writes.
// ----------------------------------------------------------------------------
// A span request is clipped to the row and queued as a word range; the
// sequencer then emits one masked write per touched 32-pixel word, one per
// cycle unless the result is held unpopped; a span touches 1 to 13 words of
// a 400-pixel row and back-to-back spans follow without a gap. Spans wholly
// outside the row produce no writes. A two-deep command queue lets new
// requests be taken while the sequencer and its output register are busy.
module masked_span_fill_1bpp_unit
  import msf1_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic      has_writes;
  span_cmd_t front_cmd;
  logic      q_valid;
  span_cmd_t q_cmd;
  logic      q_take;

  msf1_front u_front (
    .request    (request),
    .has_writes (has_writes),
    .cmd        (front_cmd)
  );

  msf1_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push && has_writes),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  msf1_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_in    (q_cmd),
    .cmd_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
